[hw/rtl/fbrt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbrt_pkg
// Shared types and constants of the erasure-code block reassembly tracker.
// ----------------------------------------------------------------------------
package fbrt_pkg;

    localparam int DEF_MAX_DATA  = 16;
    localparam int DEF_MAX_TOTAL = 32;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_GAP = 2'd3;

    // register reset values
    localparam logic [4:0]  RST_DATA_COUNT  = 5'd6;
    localparam logic [5:0]  RST_TOTAL_COUNT = 6'd12;
    localparam logic [11:0] RST_MAX_PAYLOAD = 12'd1024;
    localparam logic [15:0] RST_RESTART_GAP = 16'd100;

    // header constants
    localparam logic [7:0] VERSION_OK   = 8'd2;
    localparam logic [7:0] SIGNATURE_OK = 8'd56;

    // result status codes
    localparam logic [3:0] STAT_STORED     = 4'd0;
    localparam logic [3:0] STAT_BAD_HEADER = 4'd1;
    localparam logic [3:0] STAT_BAD_INDEX  = 4'd2;
    localparam logic [3:0] STAT_OVERSIZE   = 4'd3;
    localparam logic [3:0] STAT_OLD        = 4'd4;
    localparam logic [3:0] STAT_DUPLICATE  = 4'd5;
    localparam logic [3:0] STAT_TOO_MANY   = 4'd6;
    localparam logic [3:0] STAT_COMPLETE   = 4'd7;
    localparam logic [3:0] STAT_RECOVERED  = 4'd8;

    // block event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_ABANDON = 2'd1;
    localparam logic [1:0] EV_RESTART = 2'd2;

    typedef struct packed {
        logic [7:0]  version;
        logic [7:0]  signature;
        logic [31:0] block_number;
        logic [7:0]  pkt_idx;
        logic [15:0] pay_len;
    } t_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  block_event;
        logic [3:0]  slot;
        logic        recovered;
        logic [11:0] slot_size;
        logic [4:0]  decoder_source;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

[hw/rtl/fec_block_reassembly_tracker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fec_block_reassembly_tracker
// Header checks, block tracking and K-of-N completion for erasure-coded blocks.
// ----------------------------------------------------------------------------
// A header is taken when start is high and busy is low; busy then stays high
// until the last result is issued. A header that fails the header, index,
// size or age checks gets its single result from the block check state, a
// duplicate data header from the classify state after block check, and a
// stored data header from the tally state after block check and classify.
// A redundancy header walks the redundancy list memory an entry a cycle on
// a single comparator, up to one entry per redundancy index already held,
// and a final scan step stores it or rejects it as one too many before the
// tally. The header that completes a block then passes a setup state and
// issues K results, one slot a cycle read out of the size and redundancy
// memories. Every result is a one-cycle strobe on o_valid that the receiver
// cannot hold off. Register writes are taken in any state and belong
// between items, with nothing in flight. No clearing pass follows reset.
module fec_block_reassembly_tracker
    import fbrt_pkg::*;
#(
    parameter int MAX_DATA  = DEF_MAX_DATA,
    parameter int MAX_TOTAL = DEF_MAX_TOTAL
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output t_result              o_result
);

    localparam int DAW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int CW  = $clog2(MAX_DATA + 1);
    localparam int NW  = $clog2(MAX_TOTAL + 1);
    localparam int RW  = $clog2(MAX_TOTAL);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_BLOCK = 8'b0000_0010,
        S_CLASS = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_TALLY = 8'b0001_0000,
        S_PREP  = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // control state
    t_state              r_state, n_state;
    logic [4:0]          r_k, n_k;
    logic [5:0]          r_n, n_n;
    logic [11:0]         r_maxp, n_maxp;
    logic [15:0]         r_gap, n_gap;
    logic                r_open_ok, n_open_ok;
    logic [31:0]         r_open_blk, n_open_blk;
    logic [MAX_DATA-1:0] r_present, n_present;
    logic [CW-1:0]       r_dcnt, n_dcnt;
    logic [CW-1:0]       r_rcnt, n_rcnt;
    logic [CW-1:0]       r_scan, n_scan;
    logic [DAW-1:0]      r_i, n_i;
    logic [MAX_DATA-1:0] r_pend, n_pend;
    logic                r_recov, n_recov;
    logic [1:0]          r_ev, n_ev;
    logic                r_valid, n_valid;

    // payload
    t_item               r_item, n_item;
    t_result             r_out, n_out;

    // memories
    logic                size_we;
    logic [DAW-1:0]      size_raddr;
    logic [11:0]         size_rdata;
    logic                red_we;
    logic [DAW-1:0]      red_raddr;
    logic [RW-1:0]       red_rdata;

    // derived values
    logic [CW-1:0]       k_eff;
    logic [NW-1:0]       n_eff;
    logic [31:0]         cap;
    logic                hdr_bad, idx_bad, size_bad;
    logic                bn_older, bn_newer, very_old;
    logic                idx_is_data;
    logic                red_full;
    logic [DAW-1:0]      idx_a;
    logic [CW-1:0]       emit_next;
    logic [CW-1:0]       red_emit;
    logic [MAX_DATA-1:0] low_oh;
    logic [DAW-1:0]      low_idx;
    logic                emit_last;
    logic [CW:0]         held;

    always_comb begin
        if (r_k == 5'd0) begin
            k_eff = CW'(1);
        end else if (32'(r_k) > MAX_DATA) begin
            k_eff = CW'(MAX_DATA);
        end else begin
            k_eff = CW'(r_k);
        end
        if (32'(r_n) > MAX_TOTAL) begin
            n_eff = NW'(MAX_TOTAL);
        end else begin
            n_eff = NW'(r_n);
        end
        cap = (32'(n_eff) > 32'(k_eff)) ? 32'(n_eff) - 32'(k_eff) : 32'd0;
    end

    assign hdr_bad     = (r_item.version != VERSION_OK) || (r_item.signature != SIGNATURE_OK);
    assign idx_bad     = 32'(r_item.pkt_idx) >= 32'(n_eff);
    assign size_bad    = r_item.pay_len > 16'(r_maxp);
    assign bn_older    = r_item.block_number < r_open_blk;
    assign bn_newer    = r_item.block_number > r_open_blk;
    assign very_old    = (33'(r_item.block_number) + 33'(r_gap)) < 33'(r_open_blk);
    assign idx_is_data = 32'(r_item.pkt_idx) < 32'(k_eff);
    assign idx_a       = r_item.pkt_idx[DAW-1:0];
    assign red_full    = (32'(r_rcnt) >= cap) || (32'(r_rcnt) >= MAX_DATA);
    assign held        = (CW+1)'(r_dcnt) + (CW+1)'(r_rcnt);

    // next slot to read out; redundancy sources follow the present data slots
    assign emit_next = (r_state == S_PREP) ? '0 : CW'(r_i) + CW'(1);
    assign red_emit  = (emit_next >= r_dcnt) ? emit_next - r_dcnt : '0;
    assign emit_last = (CW'(r_i) + CW'(1)) == k_eff;

    // lowest pending data slot gives the next decoder source
    assign low_oh = r_pend & (~r_pend + MAX_DATA'(1));
    always_comb begin
        low_idx = '0;
        for (int j = 0; j < MAX_DATA; j++) begin
            if (low_oh[j]) begin
                low_idx = low_idx | DAW'(j);
            end
        end
    end

    always_comb begin
        logic       single_go;
        logic [3:0] single_stat;
        logic       clear;

        single_go   = 1'b0;
        single_stat = STAT_STORED;
        clear       = 1'b0;

        n_state    = r_state;
        n_k        = r_k;
        n_n        = r_n;
        n_maxp     = r_maxp;
        n_gap      = r_gap;
        n_open_ok  = r_open_ok;
        n_open_blk = r_open_blk;
        n_present  = r_present;
        n_dcnt     = r_dcnt;
        n_rcnt     = r_rcnt;
        n_scan     = r_scan;
        n_i        = r_i;
        n_pend     = r_pend;
        n_recov    = r_recov;
        n_ev       = r_ev;
        n_valid    = 1'b0;
        n_item     = r_item;
        n_out      = r_out;

        size_we    = 1'b0;
        red_we     = 1'b0;
        size_raddr = emit_next[DAW-1:0];
        red_raddr  = red_emit[DAW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_ev    = EV_NONE;
                    n_state = S_BLOCK;
                end
            end
            S_BLOCK: begin
                n_state = S_CLASS;
                if (hdr_bad) begin
                    single_go   = 1'b1;
                    single_stat = STAT_BAD_HEADER;
                end else if (idx_bad) begin
                    single_go   = 1'b1;
                    single_stat = STAT_BAD_INDEX;
                end else if (size_bad) begin
                    single_go   = 1'b1;
                    single_stat = STAT_OVERSIZE;
                end else if (!r_open_ok) begin
                    n_open_ok  = 1'b1;
                    n_open_blk = r_item.block_number;
                end else if (bn_older) begin
                    if (very_old) begin
                        clear      = 1'b1;
                        n_open_blk = r_item.block_number;
                        n_ev       = EV_RESTART;
                    end else begin
                        single_go   = 1'b1;
                        single_stat = STAT_OLD;
                    end
                end else if (bn_newer) begin
                    if ((r_dcnt != '0) || (r_rcnt != '0)) begin
                        n_ev = EV_ABANDON;
                    end
                    clear      = 1'b1;
                    n_open_blk = r_item.block_number;
                end
            end
            S_CLASS: begin
                if (idx_is_data) begin
                    if (r_present[idx_a]) begin
                        single_go   = 1'b1;
                        single_stat = STAT_DUPLICATE;
                    end else begin
                        n_present[idx_a] = 1'b1;
                        size_we          = 1'b1;
                        n_dcnt           = r_dcnt + CW'(1);
                        n_state          = S_TALLY;
                    end
                end else begin
                    n_scan    = '0;
                    red_raddr = '0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_scan >= r_rcnt) begin
                    if (red_full) begin
                        single_go   = 1'b1;
                        single_stat = STAT_TOO_MANY;
                    end else begin
                        red_we  = 1'b1;
                        n_rcnt  = r_rcnt + CW'(1);
                        n_state = S_TALLY;
                    end
                end else if (32'(red_rdata) == 32'(r_item.pkt_idx)) begin
                    single_go   = 1'b1;
                    single_stat = STAT_DUPLICATE;
                end else begin
                    n_scan    = r_scan + CW'(1);
                    red_raddr = DAW'(r_scan + CW'(1));
                end
            end
            S_TALLY: begin
                if (held < (CW+1)'(k_eff)) begin
                    single_go   = 1'b1;
                    single_stat = STAT_STORED;
                end else begin
                    n_recov = r_dcnt < k_eff;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_pend  = r_present;
                n_i     = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_valid              = 1'b1;
                n_out.status         = r_recov ? STAT_RECOVERED : STAT_COMPLETE;
                n_out.block_event    = r_ev;
                n_out.slot           = 4'(r_i);
                n_out.recovered      = !r_present[r_i];
                n_out.slot_size      = r_present[r_i] ? size_rdata : r_maxp;
                n_out.decoder_source = '0;
                if (r_recov) begin
                    n_out.decoder_source = (r_pend != '0) ? 5'(low_idx) : 5'(red_rdata);
                end
                n_out.last = emit_last;
                n_pend     = r_pend & (r_pend - MAX_DATA'(1));
                if (emit_last) begin
                    clear      = 1'b1;
                    n_open_blk = r_open_blk + 32'd1;
                    n_state    = S_IDLE;
                end else begin
                    n_i = r_i + DAW'(1);
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (single_go) begin
            n_valid              = 1'b1;
            n_out.status         = single_stat;
            n_out.block_event    = r_ev;
            n_out.slot           = '0;
            n_out.recovered      = 1'b0;
            n_out.slot_size      = '0;
            n_out.decoder_source = '0;
            n_out.last           = 1'b1;
            n_state              = S_IDLE;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DATA_COUNT: begin
                    n_k       = i_cfg_data[4:0];
                    clear     = 1'b1;
                    n_open_ok = 1'b0;
                end
                CFG_TOTAL_COUNT: begin
                    n_n       = i_cfg_data[5:0];
                    clear     = 1'b1;
                    n_open_ok = 1'b0;
                end
                CFG_MAX_PAYLOAD: begin
                    n_maxp = i_cfg_data[11:0];
                end
                CFG_RESTART_GAP: begin
                    n_gap = i_cfg_data;
                end
            endcase
        end

        if (clear) begin
            n_present = '0;
            n_dcnt    = '0;
            n_rcnt    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_k        <= RST_DATA_COUNT;
            r_n        <= RST_TOTAL_COUNT;
            r_maxp     <= RST_MAX_PAYLOAD;
            r_gap      <= RST_RESTART_GAP;
            r_open_ok  <= 1'b0;
            r_open_blk <= '0;
            r_present  <= '0;
            r_dcnt     <= '0;
            r_rcnt     <= '0;
            r_scan     <= '0;
            r_i        <= '0;
            r_pend     <= '0;
            r_recov    <= 1'b0;
            r_ev       <= EV_NONE;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_k        <= n_k;
            r_n        <= n_n;
            r_maxp     <= n_maxp;
            r_gap      <= n_gap;
            r_open_ok  <= n_open_ok;
            r_open_blk <= n_open_blk;
            r_present  <= n_present;
            r_dcnt     <= n_dcnt;
            r_rcnt     <= n_rcnt;
            r_scan     <= n_scan;
            r_i        <= n_i;
            r_pend     <= n_pend;
            r_recov    <= n_recov;
            r_ev       <= n_ev;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
    end

    fbrt_ram #(
        .WIDTH (12),
        .DEPTH (MAX_DATA)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size_we),
        .i_waddr (idx_a),
        .i_wdata (r_item.pay_len[11:0]),
        .i_raddr (size_raddr),
        .o_rdata (size_rdata)
    );

    fbrt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_DATA)
    ) u_red_ram (
        .i_clk   (i_clk),
        .i_we    (red_we),
        .i_waddr (r_rcnt[DAW-1:0]),
        .i_wdata (r_item.pkt_idx[RW-1:0]),
        .i_raddr (red_raddr),
        .o_rdata (red_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

[hw/rtl/fbrt_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbrt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fbrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hw/rtl/fbrt_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbrt_checker
// Port-level checks of the reassembly tracker's result sequencing.
// ----------------------------------------------------------------------------
module fbrt_checker
    import fbrt_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    o_valid,
    input wire t_result o_result
);

    // more results of the same header still to come keep the block busy
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last |-> busy)
        else $error("result burst not marked busy");

    // a completion burst has no gaps
    a_burst_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last |=> o_valid)
        else $error("gap inside result burst");

    // rejections and plain stores are single results
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status < STAT_COMPLETE) |-> o_result.last)
        else $error("single result without last");

    // a block complete without rebuild has nothing to recover
    a_complete_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status == STAT_COMPLETE)
            |-> !o_result.recovered && (o_result.decoder_source == 5'd0))
        else $error("complete block reports recovery");

    // a transfer in starts a fresh item with no stale result behind it
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("accepted item did not occupy the block");

endmodule

bind fec_block_reassembly_tracker fbrt_checker u_fbrt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
`default_nettype wire

[tb/fec_block_reassembly_tracker_tb.sv]
// ----------------------------------------------------------------------------
// fec_block_reassembly_tracker_tb
// Drives packet headers into the reassembly tracker and checks every result
// against a cycle-free prediction of the block state: header checks, block
// aging and restart, duplicate detection and K-of-N completion order. The
// run goes through several coding settings, from the reset values out to the
// extremes of each register.
// ----------------------------------------------------------------------------
module fec_block_reassembly_tracker_tb
    import fbrt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int END_DRAIN      = 20;
    localparam int MAX_PRINTED    = 40;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    t_item                i_item     = '0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_valid;
    t_result              o_result;

    fec_block_reassembly_tracker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    // predicted tracker state
    logic [4:0]  cfg_k;
    logic [5:0]  cfg_n;
    logic [11:0] cfg_max_payload;
    logic [15:0] cfg_restart_gap;
    logic        trk_open;
    logic [31:0] trk_block;
    logic        slot_held [DEF_MAX_DATA];
    logic [11:0] slot_len  [DEF_MAX_DATA];
    logic [4:0]  fec_idx   [DEF_MAX_DATA];
    int unsigned held_data;
    int unsigned held_fec;

    t_result     due_reports[$];
    t_item       header_fifo[$];
    int unsigned headers_queued;
    int unsigned headers_taken;
    int unsigned results_seen;
    int unsigned blocks_done;
    int unsigned blocks_recovered;
    int unsigned blocks_dropped;
    int unsigned sessions_restarted;
    int unsigned phases_run;
    int unsigned error_count;
    int unsigned gap_left;
    int unsigned calm_left;
    int unsigned quiet_cycles;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_k();
        if (cfg_k == 0) return 1;
        if (cfg_k > DEF_MAX_DATA) return DEF_MAX_DATA;
        return cfg_k;
    endfunction

    function automatic int unsigned eff_n();
        if (cfg_n > DEF_MAX_TOTAL) return DEF_MAX_TOTAL;
        return cfg_n;
    endfunction

    function automatic void drop_block();
        for (int i = 0; i < DEF_MAX_DATA; i++) slot_held[i] = 1'b0;
        held_data = 0;
        held_fec  = 0;
    endfunction

    function automatic void reset_tracker_model();
        cfg_k           = RST_DATA_COUNT;
        cfg_n           = RST_TOTAL_COUNT;
        cfg_max_payload = RST_MAX_PAYLOAD;
        cfg_restart_gap = RST_RESTART_GAP;
        trk_open        = 1'b0;
        trk_block       = '0;
        drop_block();
    endfunction

    function automatic void push_single(input logic [3:0] st, input logic [1:0] ev);
        t_result res;
        res             = '0;
        res.status      = st;
        res.block_event = ev;
        res.last        = 1'b1;
        due_reports.push_back(res);
    endfunction

    // works out every result one header causes and updates the tracker state
    function automatic void reassemble_header(input t_item h);
        int unsigned k;
        int unsigned n;
        int unsigned cap;
        int unsigned pos;
        int unsigned r;
        int unsigned i;
        logic [1:0]  ev;
        logic [3:0]  st;
        logic [4:0]  src [DEF_MAX_DATA];
        t_result     res;
        k  = eff_k();
        n  = eff_n();
        ev = EV_NONE;
        if (h.version != VERSION_OK || h.signature != SIGNATURE_OK) begin
            push_single(STAT_BAD_HEADER, EV_NONE);
            return;
        end
        if (h.pkt_idx >= n) begin
            push_single(STAT_BAD_INDEX, EV_NONE);
            return;
        end
        if (h.pay_len > cfg_max_payload) begin
            push_single(STAT_OVERSIZE, EV_NONE);
            return;
        end

        if (!trk_open) begin
            trk_open  = 1'b1;
            trk_block = h.block_number;
        end else if (h.block_number < trk_block) begin
            // age is taken without wrap
            if ({1'b0, h.block_number} + {17'b0, cfg_restart_gap} < {1'b0, trk_block}) begin
                drop_block();
                trk_block = h.block_number;
                ev        = EV_RESTART;
            end else begin
                push_single(STAT_OLD, EV_NONE);
                return;
            end
        end else if (h.block_number > trk_block) begin
            if (held_data > 0 || held_fec > 0) ev = EV_ABANDON;
            drop_block();
            trk_block = h.block_number;
        end

        if (h.pkt_idx < k) begin
            if (slot_held[h.pkt_idx[3:0]]) begin
                push_single(STAT_DUPLICATE, ev);
                return;
            end
            slot_held[h.pkt_idx[3:0]] = 1'b1;
            slot_len[h.pkt_idx[3:0]]  = h.pay_len[11:0];
            held_data++;
        end else begin
            cap = (n > k) ? n - k : 0;
            for (i = 0; i < held_fec && i < DEF_MAX_DATA; i++) begin
                if (fec_idx[i] == h.pkt_idx[4:0]) begin
                    push_single(STAT_DUPLICATE, ev);
                    return;
                end
            end
            if (held_fec >= cap || held_fec >= DEF_MAX_DATA) begin
                push_single(STAT_TOO_MANY, ev);
                return;
            end
            fec_idx[held_fec] = h.pkt_idx[4:0];
            held_fec++;
        end

        if (held_data + held_fec < k) begin
            push_single(STAT_STORED, ev);
            return;
        end

        // block complete: data slots first, then redundancy in arrival order
        st = (held_data >= k) ? STAT_COMPLETE : STAT_RECOVERED;
        for (i = 0; i < DEF_MAX_DATA; i++) src[i] = '0;
        pos = 0;
        for (i = 0; i < k; i++) begin
            if (slot_held[i]) begin
                src[pos] = 5'(i);
                pos++;
            end
        end
        r = 0;
        while (pos < k && r < held_fec && r < DEF_MAX_DATA) begin
            src[pos] = fec_idx[r];
            pos++;
            r++;
        end
        for (i = 0; i < k; i++) begin
            res.status         = st;
            res.block_event    = ev;
            res.slot           = 4'(i);
            res.recovered      = !slot_held[i];
            res.slot_size      = slot_held[i] ? slot_len[i] : cfg_max_payload;
            res.decoder_source = (st == STAT_RECOVERED) ? src[i] : 5'd0;
            res.last           = (i + 1 == k);
            due_reports.push_back(res);
        end
        drop_block();
        trk_block = trk_block + 32'd1;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [11:0] got,
                               input logic [11:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %0h, expected %0h",
                                   results_seen, name, got, want));
    endtask

    // random pause after a transfer: mostly none or short, a few long,
    // with runs of back-to-back headers
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 6);
        return $urandom_range(8, 40);
    endfunction

    // header driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                reassemble_header(i_item);
                headers_taken++;
                headers_queued--;
                gap_left = pick_gap();
            end
            if (!start || !busy) begin
                if (gap_left == 0 && header_fifo.size() != 0) begin
                    i_item <= header_fifo.pop_front();
                    start  <= 1'b1;
                end else begin
                    start <= 1'b0;
                    if (gap_left != 0) gap_left--;
                end
            end
        end
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (o_result.last) begin
                if (o_result.status == STAT_COMPLETE) blocks_done++;
                if (o_result.status == STAT_RECOVERED) blocks_recovered++;
                if (o_result.block_event == EV_ABANDON) blocks_dropped++;
                if (o_result.block_event == EV_RESTART) sessions_restarted++;
            end
            if (due_reports.size() == 0) begin
                report_error($sformatf("result %0d arrived with nothing expected",
                                       results_seen));
            end else begin
                want = due_reports.pop_front();
                check_field("status", o_result.status, want.status);
                check_field("block_event", o_result.block_event, want.block_event);
                check_field("slot", o_result.slot, want.slot);
                check_field("recovered", o_result.recovered, want.recovered);
                check_field("slot_size", o_result.slot_size, want.slot_size);
                check_field("decoder_source", o_result.decoder_source,
                            want.decoder_source);
                check_field("last", o_result.last, want.last);
            end
        end
        if ((start && !busy) || o_valid) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d cycles without a transfer", quiet_cycles);
            $display("fec_block_reassembly_tracker_tb NOT OK");
            $finish;
        end
    end

    function automatic t_item hdr_of(input logic [7:0] ver, input logic [7:0] sig,
                                     input logic [31:0] bn, input logic [7:0] idx,
                                     input logic [15:0] psz);
        t_item h;
        h.version      = ver;
        h.signature    = sig;
        h.block_number = bn;
        h.pkt_idx      = idx;
        h.pay_len      = psz;
        return h;
    endfunction

    function automatic void queue_header(input t_item h);
        header_fifo.push_back(h);
        headers_queued++;
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return {4'd0, cfg_max_payload};
            default: return 16'($urandom_range(0, cfg_max_payload));
        endcase
    endfunction

    // one header that breaks the normal flow of a block
    task automatic queue_noise(inout logic [31:0] bn);
        t_item       h;
        int unsigned n;
        n = eff_n();
        h = hdr_of(VERSION_OK, SIGNATURE_OK, bn,
                   8'((n == 0) ? 0 : $urandom_range(0, n - 1)), pick_size());
        case ($urandom_range(0, 5))
            0: begin
                h.version   = 8'($urandom);
                h.signature = 8'($urandom);
                if (h.version == VERSION_OK && h.signature == SIGNATURE_OK)
                    h.signature = h.signature ^ 8'h01;
            end
            1: h.pkt_idx = 8'($urandom_range(n, 255));
            2: h.pay_len = 16'($urandom_range(cfg_max_payload + 1, 16'hFFFF));
            3: h.block_number = bn - $urandom_range(1, (cfg_restart_gap == 0) ? 1
                                                       : cfg_restart_gap);
            4: begin
                // far behind: session restarts there
                h.block_number = bn - cfg_restart_gap - 32'd1 - $urandom_range(0, 50);
                bn             = h.block_number;
            end
            default: begin
                h.version      = 8'($urandom);
                h.signature    = 8'($urandom);
                h.block_number = $urandom;
                h.pkt_idx      = 8'($urandom);
                h.pay_len      = 16'($urandom);
            end
        endcase
        queue_header(h);
    endtask

    // mostly whole blocks in shuffled packet order, some cut short, with noise
    task automatic queue_random_headers(input int unsigned count);
        int unsigned k;
        int unsigned n;
        int unsigned want;
        int unsigned sent;
        int unsigned pushed;
        int unsigned i;
        int unsigned order[$];
        logic [31:0] bn;
        k      = eff_k();
        n      = eff_n();
        pushed = 0;
        case ($urandom_range(0, 3))
            0:       bn = 32'hFFFF_FFFF - $urandom_range(0, 3);
            1:       bn = $urandom_range(0, 3);
            default: bn = $urandom;
        endcase
        while (pushed < count) begin
            order.delete();
            for (i = 0; i < n; i++) order.push_back(i);
            order.shuffle();
            want = ($urandom_range(0, 9) == 0 && k > 1) ? $urandom_range(1, k - 1) : k;
            sent = 0;
            for (i = 0; i < want && i < order.size(); i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    queue_noise(bn);
                    pushed++;
                end
                if (i > 0 && $urandom_range(0, 15) == 0) begin
                    queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, bn,
                                        8'(order[$urandom_range(0, i - 1)]), pick_size()));
                    pushed++;
                end
                queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, bn, 8'(order[i]),
                                    pick_size()));
                pushed++;
                sent++;
            end
            if (sent == 0) begin
                queue_noise(bn);
                pushed++;
            end
            bn = bn + 32'd1 + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 0);
        end
    endtask

    task automatic wait_idle();
        while (headers_queued != 0 || due_reports.size() != 0 || busy !== 1'b0)
            @(posedge i_clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        logic [15:0] mask;
        logic [15:0] raw;
        case (idx)
            CFG_DATA_COUNT:  mask = 16'h001F;
            CFG_TOTAL_COUNT: mask = 16'h003F;
            CFG_MAX_PAYLOAD: mask = 16'h0FFF;
            default:         mask = 16'hFFFF;
        endcase
        // junk above the register width must be ignored
        raw = (16'($urandom) & ~mask) | (value & mask);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= raw;
        case (idx)
            CFG_DATA_COUNT: begin
                cfg_k    = raw[4:0];
                trk_open = 1'b0;
                drop_block();
            end
            CFG_TOTAL_COUNT: begin
                cfg_n    = raw[5:0];
                trk_open = 1'b0;
                drop_block();
            end
            CFG_MAX_PAYLOAD: cfg_max_payload = raw[11:0];
            default:         cfg_restart_gap = raw;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] k, input logic [15:0] n,
                             input logic [15:0] maxp, input logic [15:0] gap,
                             input int unsigned count);
        wait_idle();
        set_register(CFG_DATA_COUNT, k);
        set_register(CFG_TOTAL_COUNT, n);
        set_register(CFG_MAX_PAYLOAD, maxp);
        set_register(CFG_RESTART_GAP, gap);
        queue_random_headers(count);
        phases_run++;
    endtask

    // hand-picked headers under the reset coding of 6 of 12
    task automatic queue_directed();
        queue_header(hdr_of(8'hFD, SIGNATURE_OK, 32'd1000, 8'd0, 16'd10));
        queue_header(hdr_of(VERSION_OK, 8'hC7, 32'd1000, 8'd0, 16'd10));
        queue_header(hdr_of(8'h00, 8'hFF, 32'd1000, 8'd0, 16'd10));
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd1000, 8'd12, 16'd10));
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd1000, 8'hFF, 16'd10));
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd1000, 8'd0, 16'd1025));
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd1000, 8'd0, 16'hFFFF));
        // first packet opens block 1000
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd1000, 8'd0, 16'd1024));
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd1000, 8'd0, 16'd5));
        // old but within the restart gap
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd900, 8'd1, 16'd5));
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd1000, 8'd6, 16'd0));
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd1000, 8'd6, 16'd9));
        // newer block abandons the partial one, then a very old one restarts
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd1001, 8'd1, 16'd7));
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd0, 8'd2, 16'd33));
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd0, 8'd0, 16'd100));
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd0, 8'd1, 16'd1));
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd0, 8'd3, 16'd512));
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd0, 8'd4, 16'd2));
        // redundancy fills the missing slot
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd0, 8'd11, 16'd77));
        // skip ahead from an empty block, then abandon at the top block number
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'd5, 8'd3, 16'd3));
        queue_header(hdr_of(VERSION_OK, SIGNATURE_OK, 32'hFFFF_FFFF, 8'd7, 16'd4));
    endtask

    initial begin
        logic [15:0] rk;
        logic [15:0] rn;
        reset_tracker_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        queue_directed();

        run_phase(16'd1, 16'd2, 16'd2048, 16'd0, 50);
        run_phase(16'd16, 16'd32, 16'd4095, 16'hFFFF, 60);
        run_phase(16'd0, 16'd63, 16'd0, 16'd1, 40);
        run_phase(16'd31, 16'd20, 16'd512, 16'd100, 60);
        run_phase(16'd4, 16'd4, 16'd100, 16'd5, 40);
        run_phase(16'd8, 16'd5, 16'd300, 16'd10, 25);
        run_phase(16'd3, 16'd8, 16'($urandom_range(1, 4095)),
                  16'($urandom_range(0, 65535)), 60);
        rk = 16'($urandom_range(1, 16));
        rn = 16'($urandom_range(rk + 1, 32));
        run_phase(rk, rn, 16'($urandom_range(1, 4095)), 16'($urandom_range(0, 65535)), 60);
        run_phase(16'd6, 16'd12, 16'd1024, 16'd100, 50);

        wait_idle();
        repeat (END_DRAIN) @(posedge i_clk);
        if (due_reports.size() != 0)
            report_error($sformatf("%0d results never arrived", due_reports.size()));

        $display("run covered %0d headers over %0d codings plus reset, %0d results checked",
                 headers_taken, phases_run, results_seen);
        $display("blocks complete %0d, rebuilt %0d, abandoned %0d, restarts %0d, errors %0d",
                 blocks_done, blocks_recovered, blocks_dropped, sessions_restarted,
                 error_count);
        if (error_count == 0) begin
            $display("fec_block_reassembly_tracker_tb OK");
        end else begin
            $display("fec_block_reassembly_tracker_tb NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/fbrt_pkg.sv
hw/rtl/fbrt_ram.sv
hw/rtl/fec_block_reassembly_tracker.sv
hw/rtl/fbrt_checker.sv
tb/fec_block_reassembly_tracker_tb.sv
